/* sv/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants for the binary trie insert walk.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int ADDR_W          = 16;
  localparam int STORE_DEPTH_DEF = 65536;

  localparam logic [ADDR_W-1:0] ADDR_MAX    = 16'hFFFE;
  localparam logic [ADDR_W-1:0] NODE_STRIDE = 16'd2;

  // outcome of one trie step
  typedef struct packed {
    logic              full;
    logic              wr;
    logic [ADDR_W-1:0] cursor;
    logic [ADDR_W-1:0] next_free;
  } step_res_t;

endpackage

/* sv/bti_step_unit.sv */
// ----------------------------------------------------------------------------
// bti_step_unit
// One trie step: word index, range check, node allocation and cursor update.
// ----------------------------------------------------------------------------
module bti_step_unit #(
  parameter int STORE_DEPTH = bti_pkg::STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                        full_i,
  input  logic [bti_pkg::ADDR_W-1:0]  cursor_i,
  input  logic [bti_pkg::ADDR_W-1:0]  next_free_i,
  input  logic                        bit_i,
  input  logic [bti_pkg::ADDR_W-1:0]  rd_data_i,
  output logic [AW-1:0]               idx_o,
  output bti_pkg::step_res_t          res_o
);
  import bti_pkg::*;

  localparam int CW = (AW > ADDR_W) ? AW + 1 : ADDR_W + 2;

  logic [CW-1:0] idx_w;
  logic [CW-1:0] fresh_w;
  logic          oob;
  logic          alloc_bad;

  assign idx_w     = CW'(cursor_i) + CW'(bit_i);
  assign fresh_w   = CW'(next_free_i) + CW'(NODE_STRIDE);
  assign oob       = idx_w >= CW'(STORE_DEPTH);
  assign alloc_bad = (fresh_w > CW'(ADDR_MAX)) || ((fresh_w + CW'(1)) >= CW'(STORE_DEPTH));
  assign idx_o     = idx_w[AW-1:0];

  always_comb begin
    res_o.full      = full_i;
    res_o.wr        = 1'b0;
    res_o.cursor    = cursor_i;
    res_o.next_free = next_free_i;
    if (!full_i) begin
      if (oob) begin
        res_o.full = 1'b1;
      end else if (rd_data_i == '0) begin
        if (alloc_bad) begin
          res_o.full = 1'b1;
        end else begin
          res_o.wr        = 1'b1;
          res_o.next_free = fresh_w[ADDR_W-1:0];
          res_o.cursor    = fresh_w[ADDR_W-1:0];
        end
      end else begin
        res_o.cursor = rd_data_i;
      end
    end
  end

endmodule

/* sv/binary_trie_insert_walk.sv */
// ----------------------------------------------------------------------------
// binary_trie_insert_walk
// Each trie step: memory read (ST_READ), then evaluate/write (ST_EVAL). A byte
// item walks one step per bit, in_ready low; with key_end a terminal step and
// ST_DONE follow before out_valid, and an empty key takes only those. No new
// item is taken before the last is through; a result still held by out_ready stalls the next one.
// Reset: synchronous; then a clearing pass zeroes every node memory word,
// in_ready low meanwhile.
// ----------------------------------------------------------------------------
module binary_trie_insert_walk #(
  parameter int STORE_DEPTH = bti_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_key_byte,
  input  logic                       in_has_byte,
  input  logic                       in_key_end,
  input  logic                       in_new_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bti_pkg::ADDR_W-1:0] out_node_address,
  output logic                       out_store_full
);
  import bti_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  logic [ADDR_W-1:0] mem [STORE_DEPTH];

  state_t            state_r,     state_nxt;
  logic [AW-1:0]     clr_cnt_r,   clr_cnt_nxt;
  logic [ADDR_W-1:0] cursor_r,    cursor_nxt;
  logic [ADDR_W-1:0] next_free_r, next_free_nxt;
  logic              full_r,      full_nxt;
  logic [7:0]        byte_r,      byte_nxt;
  logic [2:0]        bit_cnt_r,   bit_cnt_nxt;
  logic              key_end_r,   key_end_nxt;
  logic              term_r,      term_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r,  out_addr_nxt;
  logic              out_full_r,  out_full_nxt;
  logic [ADDR_W-1:0] rd_r;

  logic              step_bit;
  logic [AW-1:0]     idx;
  step_res_t         res;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [ADDR_W-1:0] mem_wd;
  logic              in_acc;

  assign step_bit = byte_r[7] & ~term_r;

  bti_step_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_step (
    .full_i      (full_r),
    .cursor_i    (cursor_r),
    .next_free_i (next_free_r),
    .bit_i       (step_bit),
    .rd_data_i   (rd_r),
    .idx_o       (idx),
    .res_o       (res)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign in_acc           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_node_address = out_addr_r;
  assign out_store_full   = out_full_r;

  assign mem_we = (state_r == ST_CLEAR) || ((state_r == ST_EVAL) && res.wr);
  assign mem_wa = (state_r == ST_CLEAR) ? clr_cnt_r : idx;
  assign mem_wd = (state_r == ST_CLEAR) ? '0 : res.next_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == ST_READ) begin
      rd_r <= mem[idx];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    next_free_nxt = next_free_r;
    full_nxt      = full_r;
    byte_nxt      = byte_r;
    bit_cnt_nxt   = bit_cnt_r;
    key_end_nxt   = key_end_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_full_nxt  = out_full_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_new_key) begin
            cursor_nxt = '0;
            full_nxt   = 1'b0;
          end
          byte_nxt    = in_key_byte;
          bit_cnt_nxt = '0;
          key_end_nxt = in_key_end;
          if (in_has_byte) begin
            term_nxt  = 1'b0;
            state_nxt = ST_READ;
          end else if (in_key_end) begin
            term_nxt  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cursor_nxt    = res.cursor;
        next_free_nxt = res.next_free;
        full_nxt      = res.full;
        if (term_r) begin
          state_nxt = ST_DONE;
        end else begin
          byte_nxt    = {byte_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            if (key_end_r) begin
              term_nxt  = 1'b1;
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = full_r ? '0 : cursor_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      next_free_r <= '0;
      full_r      <= 1'b0;
      bit_cnt_r   <= '0;
      key_end_r   <= 1'b0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      next_free_r <= next_free_nxt;
      full_r      <= full_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      key_end_r   <= key_end_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_addr_r <= out_addr_nxt;
    out_full_r <= out_full_nxt;
  end

`ifndef SYNTH
  a_free_even: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r[0] == 1'b0)
    else $error("next_free odd");

  a_cursor_even: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r[0] == 1'b0)
    else $error("cursor odd");

  a_alloc_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && res.wr) |-> (rd_r == '0 && !full_r))
    else $error("allocation over a used word");

  a_full_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (out_addr_r == '0))
    else $error("nonzero address with store full");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == ST_CLEAR) && state_r == ST_IDLE |-> $past(clr_cnt_r) == AW'(STORE_DEPTH - 1))
    else $error("clear pass ended early");
`endif

endmodule
